>>> rtl/core/cbpf_pkg.sv
// Shared constants, types and small arithmetic functions for the Bezier path flattener.
// Used by the channel interfaces and by the core; depends on nothing else.
package cbpf_pkg;

  localparam int COORD_W     = 32;
  localparam int SMP_W       = 5;
  localparam int MAX_SAMPLES = 31;
  localparam int CUBE_W      = 15;
  localparam int COEF_W      = 17;
  localparam int QUO_W       = 33;
  localparam int ACC_W       = QUO_W + CUBE_W;
  localparam int PROD_W      = COORD_W + COEF_W + 1;
  localparam int STEP_W      = $clog2(QUO_W);
  localparam int CFG_DATA_W  = 5;

  localparam logic [SMP_W-1:0] SAMPLE_COUNT_RST = SMP_W'(16);

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [0:0] {
    CFG_SAMPLE_COUNT = 1'b0,
    CFG_CLOSED_PATH  = 1'b1
  } cfg_reg_t;

  function automatic logic [2*SMP_W-1:0] sq_f(input logic [SMP_W-1:0] v);
    logic [2*SMP_W-1:0] w;
    w = (2*SMP_W)'(v);
    return w * w;
  endfunction

  function automatic logic [CUBE_W-1:0] cube_f(input logic [SMP_W-1:0] v);
    logic [CUBE_W-1:0] w;
    w = CUBE_W'(v);
    return w * w * w;
  endfunction

endpackage

>>> rtl/core/cbpf_cfg_if.sv
// Configuration write channel of the Bezier path flattener.
// Depends on cbpf_pkg for the register index type and data width.
interface cbpf_cfg_if import cbpf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  cfg_reg_t              index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/cbpf_in_if.sv
// Anchor input channel of the Bezier path flattener.
// Depends on cbpf_pkg for the coordinate type.
interface cbpf_in_if import cbpf_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t anchor_x;
  coord_t anchor_y;
  coord_t handle_in_x;
  coord_t handle_in_y;
  coord_t handle_out_x;
  coord_t handle_out_y;
  logic   path_end;

  modport source (output valid, anchor_x, anchor_y, handle_in_x, handle_in_y,
                  handle_out_x, handle_out_y, path_end, input ready);
  modport sink   (input valid, anchor_x, anchor_y, handle_in_x, handle_in_y,
                  handle_out_x, handle_out_y, path_end, output ready);
endinterface

>>> rtl/core/cbpf_out_if.sv
// Polyline point output channel of the Bezier path flattener.
// Depends on cbpf_pkg for the coordinate type.
interface cbpf_out_if import cbpf_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  logic   run_last;

  modport source (output valid, point_x, point_y, run_last, input ready);
  modport sink   (input valid, point_x, point_y, run_last, output ready);
endinterface

>>> rtl/core/cubic_bezier_path_flattener_core.sv
// Cubic Bezier path flattener core: takes path anchors and emits polyline points.
// Depends on cbpf_pkg and the channel interfaces cbpf_cfg_if, cbpf_in_if and cbpf_out_if.
//
// Each anchor item is taken while the block is idle, and the block then stays busy until all
// of its points have been handed to the output register. Every point is evaluated with one
// shared 32 by 18 bit multiplier and a bit-serial divider, used for x and then for y: the
// coefficient steps, then per coordinate the multiply-accumulate steps, forming the dividend,
// the divider steps and rounding, then loading the point, which waits while the output is
// stalled. An anchor that continues a path gives sample_count points (at least one; the second
// anchor of a path first also gives the path's first anchor point, and the closing anchor of a
// closed path gives twice the points); the first anchor of a path gives no point.
module cubic_bezier_path_flattener_core import cbpf_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  cbpf_cfg_if.sink    cfg_if,
  cbpf_in_if.sink     in_if,
  cbpf_out_if.source  out_if
);

  typedef enum logic [2:0] {
    S_IDLE, S_FIRST, S_COEF, S_MAC, S_DIVLD, S_DIV, S_FIN, S_PUT
  } state_t;

  typedef enum logic [1:0] {
    SEEN_NONE, SEEN_ONE, SEEN_MANY
  } seen_t;

  localparam logic [STEP_W-1:0] COEF_LAST = STEP_W'(2);
  localparam logic [STEP_W-1:0] MAC_LAST  = STEP_W'(4);
  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(QUO_W - 1);

  state_t             state_r;
  seen_t              seen_r;
  logic [SMP_W-1:0]   sample_count_r;
  logic               closed_path_r;

  coord_t             prev_pos_x_r, prev_pos_y_r, prev_out_x_r, prev_out_y_r;
  coord_t             first_pos_x_r, first_pos_y_r, first_in_x_r, first_in_y_r;
  coord_t             cur_pos_x_r, cur_pos_y_r, cur_in_x_r, cur_in_y_r;
  coord_t             cur_out_x_r, cur_out_y_r;
  logic               end_r, two_seg_r, seg_r, coord_r;

  logic [SMP_W-1:0]   n_r, s_r;
  logic [CUBE_W-1:0]  d_r;
  logic [COEF_W-1:0]  c1_r, c2_r;
  logic [STEP_W-1:0]  step_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [CUBE_W-1:0]  rem_r;
  logic [QUO_W-1:0]   dvd_r;
  logic               neg_r;
  coord_t             px_r, py_r;

  coord_t             point_x_r, point_y_r;
  logic               run_last_r, out_valid_r;

  logic [SMP_W-1:0]   n_in, u;
  logic [SMP_W+1:0]   s3, u3;
  coord_t             p0, p1, p2, p3;
  coord_t             mul_a;
  logic [COEF_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic [ACC_W-1:0]   acc_neg, mag;
  logic [CUBE_W:0]    shifted, diff;
  logic               ge;
  logic [CUBE_W-1:0]  rem_nxt;
  logic signed [QUO_W:0] q_s;
  coord_t             q_clamp;
  logic               slot_free, seg_done, point_last, load_pt;

  assign cfg_if.ready = 1'b1;
  assign in_if.ready  = (state_r == S_IDLE);

  assign out_if.valid    = out_valid_r;
  assign out_if.point_x  = point_x_r;
  assign out_if.point_y  = point_y_r;
  assign out_if.run_last = run_last_r;

  assign slot_free  = !out_valid_r || out_if.ready;
  assign load_pt    = slot_free && (state_r == S_FIRST || state_r == S_PUT);
  assign seg_done   = (s_r == n_r);
  assign point_last = seg_done && !(!seg_r && two_seg_r);

  always_comb begin
    if (sample_count_r == '0) begin
      n_in = SMP_W'(1);
    end else if (sample_count_r > SMP_W'(MAX_SAMPLES)) begin
      n_in = SMP_W'(MAX_SAMPLES);
    end else begin
      n_in = sample_count_r;
    end
  end

  assign u  = n_r - s_r;
  assign s3 = {2'b00, s_r} + {1'b0, s_r, 1'b0};
  assign u3 = {2'b00, u} + {1'b0, u, 1'b0};

  always_comb begin
    if (!seg_r) begin
      p0 = coord_r ? prev_pos_y_r : prev_pos_x_r;
      p1 = coord_r ? prev_out_y_r : prev_out_x_r;
      p2 = coord_r ? cur_in_y_r   : cur_in_x_r;
      p3 = coord_r ? cur_pos_y_r  : cur_pos_x_r;
    end else begin
      p0 = coord_r ? cur_pos_y_r   : cur_pos_x_r;
      p1 = coord_r ? cur_out_y_r   : cur_out_x_r;
      p2 = coord_r ? first_in_y_r  : first_in_x_r;
      p3 = coord_r ? first_pos_y_r : first_pos_x_r;
    end
  end

  always_comb begin
    if (state_r == S_COEF) begin
      if (step_r == '0) begin
        mul_a = coord_t'({{(COORD_W-2*SMP_W){1'b0}}, sq_f(u)});
        mul_b = {{(COEF_W-SMP_W-2){1'b0}}, s3};
      end else begin
        mul_a = coord_t'({{(COORD_W-2*SMP_W){1'b0}}, sq_f(s_r)});
        mul_b = {{(COEF_W-SMP_W-2){1'b0}}, u3};
      end
    end else begin
      unique case (step_r[1:0])
        2'd0: begin
          mul_a = p0;
          mul_b = {{(COEF_W-CUBE_W){1'b0}}, cube_f(u)};
        end
        2'd1: begin
          mul_a = p1;
          mul_b = c1_r;
        end
        2'd2: begin
          mul_a = p2;
          mul_b = c2_r;
        end
        default: begin
          mul_a = p3;
          mul_b = {{(COEF_W-CUBE_W){1'b0}}, cube_f(s_r)};
        end
      endcase
    end
  end

  assign mul_p = mul_a * $signed({1'b0, mul_b});

  assign acc_neg = ACC_W'(-acc_r);
  assign mag     = acc_r[ACC_W-1] ? (acc_neg + {{(ACC_W-CUBE_W){1'b0}}, d_r} - ACC_W'(1))
                                  : ACC_W'(acc_r);

  assign shifted = {rem_r, dvd_r[QUO_W-1]};
  assign ge      = (shifted >= {1'b0, d_r});
  assign diff    = shifted - {1'b0, d_r};
  assign rem_nxt = ge ? diff[CUBE_W-1:0] : shifted[CUBE_W-1:0];

  assign q_s = neg_r ? -$signed({1'b0, dvd_r}) : $signed({1'b0, dvd_r});

  always_comb begin
    if ((&q_s[QUO_W:COORD_W-1]) || !(|q_s[QUO_W:COORD_W-1])) begin
      q_clamp = q_s[COORD_W-1:0];
    end else if (q_s[QUO_W]) begin
      q_clamp = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      q_clamp = {1'b0, {(COORD_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      seen_r         <= SEEN_NONE;
      sample_count_r <= SAMPLE_COUNT_RST;
      closed_path_r  <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_if.valid) begin
        unique case (cfg_if.index)
          CFG_SAMPLE_COUNT: sample_count_r <= cfg_if.data[SMP_W-1:0];
          CFG_CLOSED_PATH:  closed_path_r  <= cfg_if.data[0];
        endcase
      end

      if (out_valid_r && out_if.ready && !load_pt) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_if.valid) begin
            cur_pos_x_r <= in_if.anchor_x;
            cur_pos_y_r <= in_if.anchor_y;
            cur_in_x_r  <= in_if.handle_in_x;
            cur_in_y_r  <= in_if.handle_in_y;
            cur_out_x_r <= in_if.handle_out_x;
            cur_out_y_r <= in_if.handle_out_y;
            end_r       <= in_if.path_end;
            two_seg_r   <= in_if.path_end && closed_path_r;
            n_r         <= n_in;
            d_r         <= cube_f(n_in);
            s_r         <= SMP_W'(1);
            seg_r       <= 1'b0;
            coord_r     <= 1'b0;
            step_r      <= '0;
            if (seen_r == SEEN_NONE) begin
              first_pos_x_r <= in_if.anchor_x;
              first_pos_y_r <= in_if.anchor_y;
              first_in_x_r  <= in_if.handle_in_x;
              first_in_y_r  <= in_if.handle_in_y;
              prev_pos_x_r  <= in_if.anchor_x;
              prev_pos_y_r  <= in_if.anchor_y;
              prev_out_x_r  <= in_if.handle_out_x;
              prev_out_y_r  <= in_if.handle_out_y;
              seen_r        <= in_if.path_end ? SEEN_NONE : SEEN_ONE;
            end else if (seen_r == SEEN_ONE) begin
              state_r <= S_FIRST;
            end else begin
              state_r <= S_COEF;
            end
          end
        end

        S_FIRST: begin
          if (slot_free) begin
            point_x_r   <= first_pos_x_r;
            point_y_r   <= first_pos_y_r;
            run_last_r  <= 1'b0;
            out_valid_r <= 1'b1;
            state_r     <= S_COEF;
          end
        end

        S_COEF: begin
          prod_r <= mul_p;
          if (step_r == STEP_W'(1)) begin
            c1_r <= prod_r[COEF_W-1:0];
          end
          if (step_r == COEF_LAST) begin
            c2_r    <= prod_r[COEF_W-1:0];
            step_r  <= '0;
            state_r <= S_MAC;
          end else begin
            step_r <= step_r + STEP_W'(1);
          end
        end

        S_MAC: begin
          prod_r <= mul_p;
          if (step_r == '0) begin
            acc_r <= $signed({{(ACC_W-CUBE_W+1){1'b0}}, d_r[CUBE_W-1:1]});
          end else begin
            acc_r <= acc_r + $signed(prod_r[ACC_W-1:0]);
          end
          if (step_r == MAC_LAST) begin
            state_r <= S_DIVLD;
          end else begin
            step_r <= step_r + STEP_W'(1);
          end
        end

        S_DIVLD: begin
          rem_r   <= mag[QUO_W +: CUBE_W];
          dvd_r   <= mag[QUO_W-1:0];
          neg_r   <= acc_r[ACC_W-1];
          step_r  <= '0;
          state_r <= S_DIV;
        end

        S_DIV: begin
          rem_r <= rem_nxt;
          dvd_r <= {dvd_r[QUO_W-2:0], ge};
          if (step_r == DIV_LAST) begin
            state_r <= S_FIN;
          end else begin
            step_r <= step_r + STEP_W'(1);
          end
        end

        S_FIN: begin
          step_r <= '0;
          if (!coord_r) begin
            px_r    <= q_clamp;
            coord_r <= 1'b1;
            state_r <= S_MAC;
          end else begin
            py_r    <= q_clamp;
            state_r <= S_PUT;
          end
        end

        S_PUT: begin
          if (slot_free) begin
            point_x_r   <= px_r;
            point_y_r   <= py_r;
            run_last_r  <= point_last;
            out_valid_r <= 1'b1;
            coord_r     <= 1'b0;
            step_r      <= '0;
            if (!seg_done) begin
              s_r     <= s_r + SMP_W'(1);
              state_r <= S_COEF;
            end else if (!seg_r && two_seg_r) begin
              seg_r   <= 1'b1;
              s_r     <= SMP_W'(1);
              state_r <= S_COEF;
            end else begin
              prev_pos_x_r <= cur_pos_x_r;
              prev_pos_y_r <= cur_pos_y_r;
              prev_out_x_r <= cur_out_x_r;
              prev_out_y_r <= cur_out_y_r;
              seen_r       <= end_r ? SEEN_NONE : SEEN_MANY;
              state_r      <= S_IDLE;
            end
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> rem_r < d_r)
    else $error("divider remainder not below the divisor");

  a_point_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_PUT || state_r == S_FIRST))
    else $error("output register loaded outside a point load state");

  a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> (n_r != '0 && s_r != '0 && s_r <= n_r))
    else $error("sample index out of range");

  a_busy_after_anchor: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready && seen_r != SEEN_NONE) |=> state_r != S_IDLE)
    else $error("continuing anchor item accepted without starting work");

endmodule
